@@ sv/tccw_pkg.sv @@
// Shared constants and types for the text console cursor writer.
package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int CELL_W  = 16;
    localparam int CROW_W  = 5;
    localparam int CCOL_W  = 7;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;

    localparam op_t OP_PUT       = 2'd0;
    localparam op_t OP_BACKSPACE = 2'd1;
    localparam op_t OP_CLEAR     = 2'd2;
    localparam op_t OP_READ      = 2'd3;

    localparam cell_t            BLANK_CELL   = 16'h0020;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    localparam addr_t LAST_ROW_ADDR = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam addr_t LAST_ADDR     = ADDR_W'(CELL_COUNT - 1);
    localparam col_t  LAST_COL      = COL_W'(COLUMNS - 1);
    localparam row_t  LAST_ROW      = ROW_W'(ROWS - 1);

endpackage

@@ sv/text_console_cursor_writer.sv @@
// Text console: screen cell store, cursor, scroll and clear sequencer.
// Put, newline and backspace show their result in the cycle after the transfer
// and accept the next item in that cycle; a read passes through ST_READ before its value is shown.
// A put or newline that scrolls copies the store up one row through its read and write ports
// in ST_COPY, then blanks the last row in ST_CLEAR; clear blanks every cell in ST_CLEAR.
// Reset clears the cursor and runs a blanking pass over every cell with busy high.
// The receiver cannot stall: each result is shown for one cycle with result_valid.
module text_console_cursor_writer
    import tccw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     op,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [ATTR_W-1:0]   attr,
    input  logic [INDEX_W-1:0]  cell_index,
    output logic                result_valid,
    output logic [CELL_W-1:0]   cell_value,
    output logic [CROW_W-1:0]   cursor_row,
    output logic [CCOL_W-1:0]   cursor_col,
    output logic                did_scroll
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_COPY  = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    cell_t mem [CELL_COUNT];
    cell_t mem_q;

    logic [1:0] state_reg, state_next;
    addr_t      ptr_reg, ptr_next;
    addr_t      cur_addr_reg, cur_addr_next;
    row_t       row_reg, row_next;
    col_t       col_reg, col_next;
    logic       pend_reg, pend_next;
    logic       valid_reg, valid_next;
    logic       scroll_reg, scroll_next;
    cell_t      value_reg, value_next;
    logic       in_range_reg, in_range_next;

    logic       mem_we;
    addr_t      mem_wa;
    cell_t      mem_wd;
    addr_t      mem_ra;
    logic       accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        cur_addr_next = cur_addr_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        pend_next     = pend_reg;
        valid_next    = 1'b0;
        scroll_next   = scroll_reg;
        value_next    = value_reg;
        in_range_next = in_range_reg;
        mem_we        = 1'b0;
        mem_wa        = cur_addr_reg;
        mem_wd        = BLANK_CELL;
        mem_ra        = ADDR_W'(cell_index);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    value_next  = '0;
                    scroll_next = 1'b0;
                    unique case (op)
                        OP_PUT:
                        begin
                            if (char_code == NEWLINE_CODE)
                            begin
                                col_next      = '0;
                                cur_addr_next = ADDR_W'(cur_addr_reg - addr_t'(col_reg)
                                                + ADDR_W'(COLUMNS));
                                row_next      = ROW_W'(row_reg + 1'b1);
                            end
                            else
                            begin
                                mem_we        = 1'b1;
                                mem_wd        = {attr, char_code};
                                cur_addr_next = ADDR_W'(cur_addr_reg + 1'b1);
                                if (col_reg == LAST_COL)
                                begin
                                    col_next = '0;
                                    row_next = ROW_W'(row_reg + 1'b1);
                                end
                                else
                                begin
                                    col_next = COL_W'(col_reg + 1'b1);
                                end
                            end
                            if ((row_reg == LAST_ROW) &&
                                ((char_code == NEWLINE_CODE) || (col_reg == LAST_COL)))
                            begin
                                row_next      = LAST_ROW;
                                col_next      = '0;
                                cur_addr_next = LAST_ROW_ADDR;
                                scroll_next   = 1'b1;
                                ptr_next      = '0;
                                pend_next     = 1'b1;
                                state_next    = ST_COPY;
                            end
                            else
                            begin
                                valid_next = 1'b1;
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            if (cur_addr_reg != '0)
                            begin
                                cur_addr_next = ADDR_W'(cur_addr_reg - 1'b1);
                                mem_we        = 1'b1;
                                mem_wa        = ADDR_W'(cur_addr_reg - 1'b1);
                                if (col_reg == '0)
                                begin
                                    col_next = LAST_COL;
                                    row_next = ROW_W'(row_reg - 1'b1);
                                end
                                else
                                begin
                                    col_next = COL_W'(col_reg - 1'b1);
                                end
                            end
                            valid_next = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            row_next      = '0;
                            col_next      = '0;
                            cur_addr_next = '0;
                            ptr_next      = '0;
                            pend_next     = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        OP_READ:
                        begin
                            in_range_next = (32'(cell_index) < CELL_COUNT);
                            state_next    = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                value_next = in_range_reg ? mem_q : '0;
                valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_COPY:
            begin
                mem_ra = ADDR_W'(ptr_reg + ADDR_W'(COLUMNS));
                mem_wa = ADDR_W'(ptr_reg - 1'b1);
                mem_wd = mem_q;
                mem_we = (ptr_reg != '0);
                if (ptr_reg == LAST_ROW_ADDR)
                begin
                    state_next = ST_CLEAR;
                end
                else
                begin
                    ptr_next = ADDR_W'(ptr_reg + 1'b1);
                end
            end
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = ptr_reg;
                mem_wd = BLANK_CELL;
                if (ptr_reg == LAST_ADDR)
                begin
                    valid_next = pend_reg;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ADDR_W'(ptr_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            ptr_reg      <= '0;
            cur_addr_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            pend_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            cur_addr_reg <= cur_addr_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            pend_reg     <= pend_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scroll_reg   <= scroll_next;
        value_reg    <= value_next;
        in_range_reg <= in_range_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign cell_value   = value_reg;
    assign cursor_row   = CROW_W'(row_reg);
    assign cursor_col   = CCOL_W'(col_reg);
    assign did_scroll   = scroll_reg;

    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || result_valid))
        else $error("accepted item produced neither busy nor a result");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while sequencer busy");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && did_scroll) |-> ((row_reg == LAST_ROW) && (col_reg == '0)))
        else $error("scroll result without cursor on last row start");

    a_cursor_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
            (32'(cur_addr_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg)))
        else $error("linear cursor address out of step with row and column");

endmodule
